// ===== hw/rtl/fte_pkg.sv =====
// ----------------------------------------------------------------------------
// fte_pkg: shared types and constants of the FAT table entry engine
// Command and status codes, the decoded command record and the sequencer
// states used by the front, queue and back parts.
// ----------------------------------------------------------------------------
package fte_pkg;

  localparam int unsigned MaxClusters = 4096;
  localparam int unsigned WordCount   = MaxClusters;  // 16-bit words, two bytes each
  localparam int unsigned WordAw      = 12;
  localparam logic [12:0] MaxLimit    = 13'd4096;
  localparam logic [15:0] Fat12Mask   = 16'h0fff;
  localparam logic [15:0] EndMark12   = 16'h0ff8;
  localparam logic [15:0] EndMark16   = 16'hfff8;
  localparam logic [15:0] EndOfChain  = 16'hffff;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FIND  = 2'd2,
    CMD_ALLOC = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_UNUSED  = 2'd2,
    ST_NO_FREE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_FAT_TYPE      = 2'd0,
    CFG_CLUSTER_COUNT = 2'd1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LD0,
    S_LD1,
    S_LD2,
    S_EVAL,
    S_ST0,
    S_ST1,
    S_DONE
  } seq_state_e;

  typedef struct packed {
    logic        fat16;
    logic [12:0] limit;
  } cfg_t;

  typedef struct packed {
    cmd_e        op;
    logic [11:0] index;
    logic [15:0] value;
    logic [11:0] prev;
    logic        range_err;
    logic        prev_ok;
  } cmd_t;

endpackage

// ===== hw/rtl/fte_front.sv =====
// ----------------------------------------------------------------------------
// fte_front: configuration registers and command classification
// Holds fat_type and cluster_count, checks index and link ranges against the
// limit in force and masks the write value before queueing.
// ----------------------------------------------------------------------------
module fte_front import fte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic [1:0]  command_i,
  input  logic [11:0] index_i,
  input  logic [15:0] entry_value_i,
  input  logic [11:0] prev_cluster_i,
  output cfg_t        cfg_o,
  output cmd_t        cmd_o
);

  logic        fat16_q;
  logic [12:0] count_q;
  logic [12:0] limit;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fat16_q <= 1'b0;
      count_q <= MaxLimit;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_FAT_TYPE:      fat16_q <= cfg_data_i[0];
        CFG_CLUSTER_COUNT: count_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  assign limit = (count_q > MaxLimit) ? MaxLimit : count_q;
  assign cfg_o = '{fat16: fat16_q, limit: limit};

  always_comb begin
    cmd_o.op        = cmd_e'(command_i);
    cmd_o.index     = index_i;
    cmd_o.value     = fat16_q ? entry_value_i : (entry_value_i & Fat12Mask);
    cmd_o.prev      = prev_cluster_i;
    cmd_o.range_err = (index_i == 12'd0) || ({1'b0, index_i} >= limit);
    cmd_o.prev_ok   = (prev_cluster_i >= 12'd2) && ({1'b0, prev_cluster_i} < limit);
  end

endmodule

// ===== hw/rtl/fte_queue.sv =====
// ----------------------------------------------------------------------------
// fte_queue: two-entry command queue
// Decouples command acceptance from the table sequencer.
// ----------------------------------------------------------------------------
module fte_queue import fte_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t pop_data_o
);

  cmd_t       slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ===== hw/rtl/fte_back.sv =====
// ----------------------------------------------------------------------------
// fte_back: table store and command sequencer
// Owns the byte store as 16-bit words with byte enables, clears it after
// reset, and runs load, store and scan steps for each queued command.
// ----------------------------------------------------------------------------
module fte_back import fte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        q_empty_i,
  input  cmd_t        q_data_i,
  output logic        q_pop_o,
  output logic        clearing_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] out_data_o,
  output logic [1:0]  out_status_o
);

  logic [15:0] mem [WordCount];
  logic [15:0] rdata_q;

  seq_state_e  state_q, state_d;
  cmd_t        op_q, op_d;
  logic [11:0] cur_q, cur_d;
  logic [11:0] found_q, found_d;
  logic        link_q, link_d;
  logic [7:0]  lo_q, lo_d, hi_q, hi_d;
  logic [15:0] wval_q, wval_d;
  logic [15:0] res_data_q, res_data_d;
  status_e     res_st_q, res_st_d;
  logic [11:0] clr_q, clr_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] out_data_q;
  logic [1:0]  out_status_q;

  logic          mem_re, mem_we;
  logic [1:0]    mem_be;
  logic [WordAw-1:0] mem_addr;
  logic [15:0]   mem_wdata;

  logic [12:0] byte_addr;
  logic [15:0] entry;
  logic [15:0] end_mark;
  logic [7:0]  nlo, nhi;
  logic        slot_free, load_out;
  logic        split;

  // byte address of entry cur: n*3/2 for packed entries, 2n otherwise
  assign byte_addr = cfg_i.fat16 ? {cur_q, 1'b0} : ({1'b0, cur_q} + {2'b0, cur_q[11:1]});
  assign split     = byte_addr[0];
  assign end_mark  = cfg_i.fat16 ? EndMark16 : EndMark12;
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    if (cfg_i.fat16)    entry = {hi_q, lo_q};
    else if (!cur_q[0]) entry = {4'h0, hi_q[3:0], lo_q};
    else                entry = {4'h0, hi_q, lo_q[7:4]};
  end

  always_comb begin
    if (cfg_i.fat16) begin
      nlo = wval_q[7:0];
      nhi = wval_q[15:8];
    end else if (!cur_q[0]) begin
      nlo = wval_q[7:0];
      nhi = {hi_q[7:4], wval_q[11:8]};
    end else begin
      nlo = {wval_q[3:0], lo_q[3:0]};
      nhi = wval_q[11:4];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      if (mem_be[0]) mem[mem_addr][7:0]  <= mem_wdata[7:0];
      if (mem_be[1]) mem[mem_addr][15:8] <= mem_wdata[15:8];
    end
    if (mem_re) rdata_q <= mem[mem_addr];
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    cur_d      = cur_q;
    found_d    = found_q;
    link_d     = link_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    wval_d     = wval_q;
    res_data_d = res_data_q;
    res_st_d   = res_st_q;
    clr_d      = clr_q;
    q_pop_o    = 1'b0;
    load_out   = 1'b0;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    mem_be     = 2'b00;
    mem_addr   = byte_addr[12:1];
    mem_wdata  = '0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_be    = 2'b11;
        mem_addr  = clr_q;
        clr_d     = clr_q + 12'd1;
        if (clr_q == 12'(WordCount - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o    = 1'b1;
          op_d       = q_data_i;
          cur_d      = q_data_i.index;
          wval_d     = q_data_i.value;
          link_d     = 1'b0;
          res_data_d = '0;
          res_st_d   = ST_OK;
          unique case (q_data_i.op)
            CMD_READ, CMD_WRITE: begin
              if (q_data_i.range_err) begin
                res_st_d = ST_RANGE;
                state_d  = S_DONE;
              end else begin
                state_d = S_LD0;
              end
            end
            default: begin
              cur_d = 12'd2;
              if (cfg_i.limit <= 13'd2) begin
                res_st_d = ST_NO_FREE;
                state_d  = S_DONE;
              end else begin
                state_d = S_LD0;
              end
            end
          endcase
        end
      end
      S_LD0: begin
        mem_re  = 1'b1;
        state_d = S_LD1;
      end
      S_LD1: begin
        if (!cfg_i.fat16 && split) begin
          lo_d     = rdata_q[15:8];
          mem_re   = 1'b1;
          mem_addr = byte_addr[12:1] + 12'd1;
          state_d  = S_LD2;
        end else begin
          lo_d    = rdata_q[7:0];
          hi_d    = rdata_q[15:8];
          state_d = S_EVAL;
        end
      end
      S_LD2: begin
        hi_d    = rdata_q[7:0];
        state_d = S_EVAL;
      end
      S_EVAL: begin
        unique case (op_q.op)
          CMD_READ: begin
            if (entry <= 16'd1 || entry >= end_mark) res_st_d = ST_UNUSED;
            else res_data_d = entry;
            state_d = S_DONE;
          end
          CMD_WRITE: state_d = S_ST0;
          default: begin
            if (link_q) begin
              state_d = S_ST0;
            end else if (entry == 16'd0) begin
              if (op_q.op == CMD_FIND) begin
                res_data_d = {4'h0, cur_q};
                state_d    = S_DONE;
              end else begin
                wval_d  = cfg_i.fat16 ? EndOfChain : (EndOfChain & Fat12Mask);
                state_d = S_ST0;
              end
            end else if ({1'b0, cur_q} + 13'd1 < cfg_i.limit) begin
              cur_d   = cur_q + 12'd1;
              state_d = S_LD0;
            end else begin
              res_st_d = ST_NO_FREE;
              state_d  = S_DONE;
            end
          end
        endcase
      end
      S_ST0, S_ST1: begin
        mem_we = 1'b1;
        if (!split) begin
          mem_be    = 2'b11;
          mem_wdata = {nhi, nlo};
        end else if (state_q == S_ST0) begin
          mem_be    = 2'b10;
          mem_wdata = {nlo, 8'h00};
        end else begin
          mem_be    = 2'b01;
          mem_addr  = byte_addr[12:1] + 12'd1;
          mem_wdata = {8'h00, nhi};
        end
        if (split && state_q == S_ST0) begin
          state_d = S_ST1;
        end else if (op_q.op == CMD_ALLOC && !link_q) begin
          found_d    = cur_q;
          res_data_d = {4'h0, cur_q};
          if (op_q.prev_ok) begin
            // reload the linked entry, bytes may be shared with the new one
            link_d  = 1'b1;
            cur_d   = op_q.prev;
            wval_d  = {4'h0, cur_q};
            state_d = S_LD0;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          if (op_q.op == CMD_ALLOC) res_data_d = {4'h0, found_q};
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    cur_q      <= cur_d;
    found_q    <= found_d;
    link_q     <= link_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    wval_q     <= wval_d;
    res_data_q <= res_data_d;
    res_st_q   <= res_st_d;
    if (load_out) begin
      out_data_q   <= res_data_q;
      out_status_q <= res_st_q;
    end
  end

  assign clearing_o   = (state_q == S_CLEAR);
  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_data_q;
  assign out_status_o = out_status_q;

endmodule

// ===== hw/rtl/fat_table_entry_engine_unit.sv =====
// ----------------------------------------------------------------------------
// fat_table_entry_engine_unit: FAT12/FAT16 table entry engine
// Read, write, find-free and allocate-and-link on one table image.
// ----------------------------------------------------------------------------
// Channel   Direction  Transaction
// s_axis    in         one command: command, index, entry_value, prev_cluster
// m_axis    out        one result per command: data, status
// cfg       in         register write: index 0 fat_type, 1 cluster_count
//
// With an idle sequencer a read loads and evaluates its entry before the
// result, and a write adds a store; a packed entry that spans two words takes
// two word accesses per load and per store. An out-of-range index returns
// with no load. A scan evaluates one entry after another over the single
// store port. Allocate adds a store and, with a link, a load and a store.
// After reset a clearing pass zeroes all 4096 words of the store; s_axis_tready
// stays low meanwhile. Up to two commands queue ahead of the sequencer, and
// a finished result waits in the output register while m_axis_tready is low.
// ----------------------------------------------------------------------------
module fat_table_entry_engine_unit import fte_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] command, [13:2] index, [29:14] entry_value, [41:30] prev_cluster
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] data, [17:16] status
  output logic [23:0] m_axis_tdata
);

  cfg_t        cfg;
  cmd_t        cmd_in, cmd_out;
  logic        q_full, q_empty, q_pop, clearing, push;
  logic [15:0] out_data;
  logic [1:0]  out_status;

  fte_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .command_i      (s_axis_tdata[1:0]),
    .index_i        (s_axis_tdata[13:2]),
    .entry_value_i  (s_axis_tdata[29:14]),
    .prev_cluster_i (s_axis_tdata[41:30]),
    .cfg_o          (cfg),
    .cmd_o          (cmd_in)
  );

  assign s_axis_tready = !q_full && !clearing;
  assign push          = s_axis_tvalid && s_axis_tready;

  fte_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (cmd_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .pop_data_o  (cmd_out)
  );

  fte_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .q_empty_i    (q_empty),
    .q_data_i     (cmd_out),
    .q_pop_o      (q_pop),
    .clearing_o   (clearing),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (out_data),
    .out_status_o (out_status)
  );

  assign m_axis_tdata = {6'b0, out_status, out_data};

endmodule
